// ----- rtl/ncen_pkg.sv -----
// ----------------------------------------------------------------------------
// ncen_pkg
// Shared constants, register indexes and helpers of the network coding end
// node controller.
// ----------------------------------------------------------------------------
package ncen_pkg;

  // Largest payload that the packet stores can hold
  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] BEACON_ID = 8'h00;

  // Register reset values
  localparam logic [BYTE_W-1:0] NODE_ID_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] RELAY_ID_RST   = 8'd3;
  localparam logic [LEN_W-1:0]  PACKET_LEN_RST = 6'd32;
  localparam logic [BYTE_W-1:0] PKT_NUM_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] PKT_NUM_TOP    = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LEN = 2'd2;

  // Item kinds
  localparam logic KIND_LINK   = 1'b0;
  localparam logic KIND_SOURCE = 1'b1;

  // Clamp the programmed length to 1..MAX_PAYLOAD
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

endpackage

// ----- rtl/network_coding_end_node_ctrl.sv -----
// An idle or checking link byte gives its zero result after the transfer.
// A transmit burst sends its header bytes, then each payload byte after a
// registered read of the packet RAMs; any output stall holds it.
// Throughput: one item at a time; input is not ready while an item is worked.
// Reset: synchronous; restores the configuration registers, clears control state and the origin valid bits.
// ----------------------------------------------------------------------------
// network_coding_end_node_ctrl
// End node of a two-way relay with network coding: classifies relay packets,
// decodes coded packets against the stored origin data and sends bursts.
// ----------------------------------------------------------------------------
module network_coding_end_node_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  // Input item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [ncen_pkg::BYTE_W-1:0]    data_byte,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ncen_pkg::BYTE_W-1:0]    link_byte,
  output logic [ncen_pkg::BYTE_W-1:0]    decoded_byte,
  output logic                           last,
  // Configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ncen_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ncen_pkg::BYTE_W-1:0]    cfg_data
);

  import ncen_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_CHECK,
    M_STORE,
    M_LOAD
  } mode_t;

  typedef enum logic [3:0] {
    S_IN,
    S_IDLE_CMP,
    S_CHK_BCN,
    S_CHK_NUM,
    S_CHK_END,
    S_ZERO,
    S_STORE,
    S_NUM_INC,
    S_LD,
    S_HDR,
    S_BRD,
    S_BPUT
  } state_t;

  typedef enum logic [1:0] {
    U_EQ,
    U_XOR,
    U_INC
  } uop_t;

  // Configuration registers
  logic [BYTE_W-1:0] node_id;
  logic [BYTE_W-1:0] relay_id;
  logic [LEN_W-1:0]  packet_len;

  // Control state
  state_t            state;
  mode_t             mode;
  logic [1:0]        check_count;
  logic [1:0]        beacon_hits;
  logic [1:0]        number_hits;
  logic              beacon_seen;
  logic              coded_seen;
  logic              decoded_valid;
  logic [BYTE_W-1:0] packet_number;
  logic [LEN_W-1:0]  byte_index;
  logic [LEN_W-1:0]  burst_idx;
  logic [2:0]        hdr_cnt;
  logic              zero_last;
  logic              burst_pend;
  logic [BYTE_W-1:0] item_byte;
  logic              origin_valid [MAX_PAYLOAD];

  // Shared byte unit
  uop_t              uop;
  logic [BYTE_W-1:0] opa;
  logic [BYTE_W-1:0] opb;
  logic [BYTE_W-1:0] alu_y;
  logic              alu_eq;

  // RAM ports
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] org_rdata;
  logic [BYTE_W-1:0] dec_rdata;
  logic [BYTE_W-1:0] origin_byte;
  logic              org_we;
  logic [ADDR_W-1:0] org_waddr;
  logic              dec_we;
  logic [LEN_W-1:0]  load_pos;

  // Result push
  logic              out_free;
  logic              push;
  logic [BYTE_W-1:0] push_link;
  logic [BYTE_W-1:0] push_dec;
  logic              push_last;

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  byte_index_inc;
  logic [LEN_W:0]    burst_idx_inc;
  logic              burst_done;

  // Check decision
  logic              chk_coded;
  logic              chk_tx;
  mode_t             chk_next;
  logic              chk_beacon_first;

  // Take register writes only between items
  assign cfg_ready = (state == S_IN);
  assign in_ready  = (state == S_IN);
  assign out_free  = !out_valid || out_ready;
  assign len_eff   = eff_len(packet_len);

  assign byte_index_inc = byte_index + LEN_W'(1);
  assign burst_idx_inc  = {1'b0, burst_idx} + (LEN_W+1)'(1);
  assign burst_done     = (burst_idx_inc >= {1'b0, len_eff});
  assign load_pos       = byte_index - LEN_W'(1);

  // Select operands and operation of the shared byte unit
  always_comb begin
    uop = U_EQ;
    opa = item_byte;
    opb = relay_id;
    case (state)
      S_CHK_BCN: opb = BEACON_ID;
      S_CHK_NUM: opb = packet_number;
      S_STORE: begin
        uop = U_XOR;
        opb = origin_byte;
      end
      S_NUM_INC: begin
        uop = U_INC;
        opa = packet_number;
        opb = PKT_NUM_TOP;
      end
      default: ;
    endcase
  end

  // Shared byte unit: compare, xor, or wrapping increment
  always_comb begin
    alu_eq = (opa == opb);
    case (uop)
      U_XOR:   alu_y = opa ^ opb;
      U_INC:   alu_y = alu_eq ? PKT_NUM_RST : opa + BYTE_W'(1);
      default: alu_y = opa;
    endcase
  end

  // Read from the current store index, or the burst index during a burst
  always_comb begin
    if (state == S_HDR || state == S_BRD || state == S_BPUT) begin
      rd_addr = burst_idx[ADDR_W-1:0];
    end else begin
      rd_addr = byte_index[ADDR_W-1:0];
    end
  end

  // Origin entries never loaded read as zero
  assign origin_byte = origin_valid[rd_addr] ? org_rdata : '0;

  assign org_we    = (state == S_LD) && (byte_index != '0) && (load_pos < MAX_LEN);
  assign org_waddr = load_pos[ADDR_W-1:0];
  assign dec_we    = (state == S_STORE) && (byte_index < MAX_LEN);

  ncen_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_origin_ram (
    .clk   (clk),
    .we    (org_we),
    .waddr (org_waddr),
    .wdata (item_byte),
    .raddr (rd_addr),
    .rdata (org_rdata)
  );

  ncen_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_decoded_ram (
    .clk   (clk),
    .we    (dec_we),
    .waddr (byte_index[ADDR_W-1:0]),
    .wdata (alu_y),
    .raddr (rd_addr),
    .rdata (dec_rdata)
  );

  // Decide the outcome of a completed three-byte check
  always_comb begin
    chk_coded        = coded_seen;
    chk_tx           = 1'b0;
    chk_next         = M_IDLE;
    chk_beacon_first = 1'b0;
    if (number_hits >= 2'd2) begin
      chk_coded = 1'b1;
      chk_next  = M_STORE;
    end else begin
      chk_tx = 1'b1;
    end
    if (!chk_coded) begin
      chk_tx = 1'b0;
      if (beacon_hits >= 2'd2) begin
        if (!beacon_seen) begin
          chk_beacon_first = 1'b1;
          chk_next         = M_LOAD;
        end else begin
          chk_tx = 1'b1;
        end
      end
    end
  end

  // Build the result to push in the current state
  always_comb begin
    push      = 1'b0;
    push_link = '0;
    push_dec  = '0;
    push_last = 1'b0;
    case (state)
      S_ZERO: begin
        push      = out_free;
        push_last = zero_last;
      end
      S_HDR: begin
        push      = out_free;
        push_link = (hdr_cnt < 3'd3) ? node_id : packet_number;
        push_dec  = (decoded_valid && hdr_cnt == 3'd5) ? node_id : '0;
      end
      S_BPUT: begin
        push      = out_free;
        push_link = origin_byte;
        push_dec  = decoded_valid ? dec_rdata : '0;
        push_last = burst_done;
      end
      default: ;
    endcase
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id       <= NODE_ID_RST;
      relay_id      <= RELAY_ID_RST;
      packet_len    <= PACKET_LEN_RST;
      state         <= S_IN;
      mode          <= M_IDLE;
      check_count   <= '0;
      beacon_hits   <= '0;
      number_hits   <= '0;
      beacon_seen   <= 1'b0;
      coded_seen    <= 1'b0;
      decoded_valid <= 1'b0;
      packet_number <= PKT_NUM_RST;
      byte_index    <= '0;
      burst_idx     <= '0;
      hdr_cnt       <= '0;
      zero_last     <= 1'b0;
      burst_pend    <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
        origin_valid[i] <= 1'b0;
      end
    end else begin
      // Configuration writes; unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_ID:    node_id    <= cfg_data;
          CFG_RELAY_ID:   relay_id   <= cfg_data;
          CFG_PACKET_LEN: packet_len <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      // Output register: load on push, drop after transfer
      if (push) begin
        out_valid    <= 1'b1;
        link_byte    <= push_link;
        decoded_byte <= push_dec;
        last         <= push_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (org_we) begin
        origin_valid[org_waddr] <= 1'b1;
      end

      case (state)
        // Take an item and dispatch on mode; drop unexpected kinds
        S_IN: begin
          if (in_valid) begin
            item_byte <= data_byte;
            case (mode)
              M_IDLE:  if (req_type == KIND_LINK) state <= S_IDLE_CMP;
              M_CHECK: if (req_type == KIND_LINK) state <= S_CHK_BCN;
              M_STORE: if (req_type == KIND_LINK) state <= S_STORE;
              M_LOAD:  if (req_type == KIND_SOURCE) state <= S_LD;
              default: mode <= M_IDLE;
            endcase
          end
        end

        // Relay id starts a check
        S_IDLE_CMP: begin
          if (alu_eq) mode <= M_CHECK;
          zero_last  <= 1'b1;
          burst_pend <= 1'b0;
          state      <= S_ZERO;
        end

        // Count beacon matches while no coded packet was seen
        S_CHK_BCN: begin
          check_count <= check_count + 2'd1;
          if (alu_eq && !coded_seen && beacon_hits < 2'd3) begin
            beacon_hits <= beacon_hits + 2'd1;
          end
          state <= S_CHK_NUM;
        end

        // Count packet-number matches
        S_CHK_NUM: begin
          if (alu_eq && number_hits < 2'd3) begin
            number_hits <= number_hits + 2'd1;
          end
          state <= S_CHK_END;
        end

        // Close the check after its third byte
        S_CHK_END: begin
          if (check_count == 2'd3) begin
            coded_seen  <= chk_coded;
            number_hits <= '0;
            if (!chk_coded) beacon_hits <= '0;
            if (chk_beacon_first) beacon_seen <= 1'b1;
            check_count <= '0;
            byte_index  <= '0;
            mode        <= chk_next;
            zero_last   <= !chk_tx;
            burst_pend  <= chk_tx;
          end else begin
            zero_last  <= 1'b1;
            burst_pend <= 1'b0;
          end
          state <= S_ZERO;
        end

        // Send the zero result, then the burst if one is due
        S_ZERO: begin
          if (out_free) begin
            if (burst_pend) begin
              hdr_cnt <= '0;
              state   <= S_HDR;
            end else begin
              state <= S_IN;
            end
          end
        end

        // Decode one coded byte against the origin data
        S_STORE: begin
          if (byte_index_inc >= len_eff) begin
            byte_index    <= '0;
            decoded_valid <= 1'b1;
            mode          <= M_LOAD;
            state         <= S_NUM_INC;
          end else begin
            byte_index <= byte_index_inc;
            state      <= S_IN;
          end
        end

        // Advance the packet number, wrapping past the top to one
        S_NUM_INC: begin
          packet_number <= alu_y;
          state         <= S_IN;
        end

        // Skip the first source byte, then fill the origin store
        S_LD: begin
          if (byte_index == '0) begin
            byte_index <= LEN_W'(1);
            state      <= S_IN;
          end else if (byte_index_inc > len_eff) begin
            byte_index <= '0;
            hdr_cnt    <= '0;
            state      <= S_HDR;
          end else begin
            byte_index <= byte_index_inc;
            state      <= S_IN;
          end
        end

        // Header and packet-number bytes of a burst
        S_HDR: begin
          if (out_free) begin
            hdr_cnt <= hdr_cnt + 3'd1;
            if (hdr_cnt == 3'd5) begin
              burst_idx <= '0;
              state     <= S_BRD;
            end
          end
        end

        // Wait for the registered RAM read
        S_BRD: state <= S_BPUT;

        // Payload bytes of a burst
        S_BPUT: begin
          if (out_free) begin
            if (burst_done) begin
              decoded_valid <= 1'b0;
              mode          <= M_IDLE;
              state         <= S_IN;
            end else begin
              burst_idx <= burst_idx_inc[LEN_W-1:0];
              state     <= S_BRD;
            end
          end
        end

        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_decoded_in_load: assert property (@(posedge clk) disable iff (rst)
    decoded_valid |-> mode == M_LOAD)
    else $error("decoded data pending outside load mode");

  // Beacon hits of the check that first finds a coded packet are kept
  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    (mode != M_CHECK && state == S_IN) |->
      (check_count == '0 && number_hits == '0 && (coded_seen || beacon_hits == '0)))
    else $error("check counters not cleared outside check");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid) |-> out_ready)
    else $error("result pushed over a pending result");

  a_pkt_num_nonzero: assert property (@(posedge clk) disable iff (rst)
    packet_number != '0)
    else $error("packet number reached zero");
`endif

endmodule

// ----- rtl/ncen_ram.sv -----
// ----------------------------------------------------------------------------
// ncen_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
